/* hdl/bounded_double_ended_queue_assert.svh */
// assertion macros for the deque block
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_ASSERT_SVH

`ifndef SYNTH
`define BDQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("deque check failed");
`define BDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed");
`else
`define BDQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define BDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/dq_pkg.sv */
`default_nettype none

package dq_pkg;

    localparam int WORD_W        = 32;
    localparam int CMD_W         = 3;
    localparam int STATUS_W      = 2;
    localparam int DEFAULT_DEPTH = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_LIST       = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LIST,
        S_POPB
    } state_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } chain_ctl_t;

endpackage

`default_nettype wire

/* hdl/bounded_double_ended_queue.sv */
`default_nettype none

// Bounded deque of signed 32-bit words held in a row of DEPTH cells, cell
// zero holding the front word while idle. Push front, push back and pop
// front need no rotation: the whole row shifts by one or a single cell
// loads. With two or more words held, a pop back runs entry_count - 1
// rotations of the row to bring the back word into cell zero, then one
// pop; with one word it is handled like a pop front. A list of a non-empty
// deque sends one word per entry, rotating the row once per word sent, so
// the row ends where it began; a list of an empty deque sends a single word.
// A stalled response holds up each list word and the final pop of a pop
// back. The command side is held off while a list or a pop back is running.
// Every command but the unused codes gives a response word; last marks the
// final word of a command. The result register lets a new command in while
// the previous response is being taken. No clearing pass after reset.

`include "bounded_double_ended_queue_assert.svh"

module bounded_double_ended_queue #(
    parameter int DEPTH = dq_pkg::DEFAULT_DEPTH
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cmd_valid,
    output logic                              cmd_ready,
    input  wire        [dq_pkg::CMD_W-1:0]    command,
    input  wire signed [dq_pkg::WORD_W-1:0]   value,
    output logic                              rsp_valid,
    input  wire                               rsp_ready,
    output logic       [dq_pkg::STATUS_W-1:0] status,
    output logic signed [dq_pkg::WORD_W-1:0]  data_out,
    output logic                              last
);
    import dq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    chain_ctl_t               ctl;
    logic [CNT_W-1:0]         count;
    logic signed [WORD_W-1:0] cell_data [DEPTH];

    // sequencer: command decode, entry count, rotation counter, result reg
    dq_ctrl #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .command   (command),
        .head      (cell_data[0]),
        .ctl       (ctl),
        .count     (count),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .data_out  (data_out),
        .last      (last)
    );

    // the row: each cell talks to its two neighbors, cell zero is the front
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [WORD_W-1:0] left_w;
        logic signed [WORD_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            // a front push feeds the new word into cell zero
            assign left_w = value;
        end
        else
        begin : g_mid
            assign left_w = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_end
            assign right_w = cell_data[i];
        end
        else
        begin : g_inner
            assign right_w = cell_data[i+1];
        end

        dq_cell #(
            .DEPTH (DEPTH),
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk   (clk),
            .ctl   (ctl),
            .count (count),
            .word  (value),
            .head  (cell_data[0]),
            .left  (left_w),
            .right (right_w),
            .data  (cell_data[i])
        );
    end

    // entry count never passes the row length
    `BDQ_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count <= CNT_W'(DEPTH))

    // a stalled response blocks new commands
    `BDQ_ASSERT_ALWAYS(a_stall_blocks, clk, rst_n, !(rsp_valid && !rsp_ready && cmd_ready))

    // an accepted push into a non-full deque grows it by one
    `BDQ_ASSERT_NEXT(a_push_grows, clk, rst_n,
        cmd_valid && cmd_ready && count != CNT_W'(DEPTH) &&
        (command == CMD_PUSH_FRONT || command == CMD_PUSH_BACK),
        count == $past(count) + 1'b1)

endmodule

`default_nettype wire

/* hdl/dq_cell.sv */
`default_nettype none

module dq_cell #(
    parameter int DEPTH = 16,
    parameter int IDX   = 0,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire                               clk,
    input  dq_pkg::chain_ctl_t                ctl,
    input  wire        [CNT_W-1:0]            count,
    input  wire signed [dq_pkg::WORD_W-1:0]   word,
    input  wire signed [dq_pkg::WORD_W-1:0]   head,
    input  wire signed [dq_pkg::WORD_W-1:0]   left,
    input  wire signed [dq_pkg::WORD_W-1:0]   right,
    output logic signed [dq_pkg::WORD_W-1:0]  data
);
    import dq_pkg::*;

    logic signed [WORD_W-1:0] data_reg;
    logic signed [WORD_W-1:0] data_next;
    logic                     is_slot;
    logic                     is_tail;
    logic                     is_inner;

    // position of this cell relative to the live region
    assign is_slot  = (count == CNT_W'(IDX));
    assign is_tail  = (count == CNT_W'(IDX + 1));
    assign is_inner = (CNT_W'(IDX + 1) < count);

    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            OP_PUSH_FRONT: data_next = left;
            OP_PUSH_BACK:
            begin
                if (is_slot)
                    data_next = word;
            end
            OP_POP_FRONT:  data_next = right;
            OP_ROTATE:
            begin
                if (is_inner)
                    data_next = right;
                else if (is_tail)
                    data_next = head;
            end
            default:       data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

/* hdl/dq_ctrl.sv */
`default_nettype none

module dq_ctrl #(
    parameter int DEPTH = 16,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cmd_valid,
    output logic                              cmd_ready,
    input  wire        [dq_pkg::CMD_W-1:0]    command,
    input  wire signed [dq_pkg::WORD_W-1:0]   head,
    output dq_pkg::chain_ctl_t                ctl,
    output logic       [CNT_W-1:0]            count,
    output logic                              rsp_valid,
    input  wire                               rsp_ready,
    output logic       [dq_pkg::STATUS_W-1:0] status,
    output logic signed [dq_pkg::WORD_W-1:0]  data_out,
    output logic                              last
);
    import dq_pkg::*;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         rem_reg, rem_next;
    logic                     valid_reg, valid_next;
    status_t                  status_reg, status_next;
    logic signed [WORD_W-1:0] data_reg, data_next;
    logic                     last_reg, last_next;
    logic                     out_free;
    logic                     full;
    logic                     empty;
    logic                     emit;

    assign out_free = !valid_reg || rsp_ready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rem_next    = rem_reg;
        ctl.op      = OP_HOLD;
        emit        = 1'b0;
        status_next = status_reg;
        data_next   = data_reg;
        last_next   = last_reg;
        cmd_ready   = (state_reg == S_IDLE) && out_free;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && cmd_ready)
                begin
                    case (command)
                        CMD_PUSH_FRONT, CMD_PUSH_BACK:
                        begin
                            emit        = 1'b1;
                            data_next   = '0;
                            last_next   = 1'b1;
                            if (full)
                                status_next = ST_OVER;
                            else
                            begin
                                status_next = ST_OK;
                                ctl.op      = (command == CMD_PUSH_FRONT) ?
                                              OP_PUSH_FRONT : OP_PUSH_BACK;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK:
                        begin
                            if (empty)
                            begin
                                emit        = 1'b1;
                                status_next = ST_UNDER;
                                data_next   = '0;
                                last_next   = 1'b1;
                            end
                            else if (command == CMD_POP_FRONT ||
                                     count_reg == CNT_W'(1))
                            begin
                                emit        = 1'b1;
                                status_next = ST_OK;
                                data_next   = head;
                                last_next   = 1'b1;
                                ctl.op      = OP_POP_FRONT;
                                count_next  = count_reg - 1'b1;
                            end
                            else
                            begin
                                // bring the back word round to cell zero
                                rem_next   = count_reg - 1'b1;
                                state_next = S_POPB;
                            end
                        end
                        CMD_LIST:
                        begin
                            if (empty)
                            begin
                                emit        = 1'b1;
                                status_next = ST_EMPTY;
                                data_next   = '0;
                                last_next   = 1'b1;
                            end
                            else
                            begin
                                rem_next   = count_reg;
                                state_next = S_LIST;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    status_next = ST_OK;
                    data_next   = head;
                    last_next   = (rem_reg == CNT_W'(1));
                    ctl.op      = OP_ROTATE;
                    rem_next    = rem_reg - 1'b1;
                    if (rem_reg == CNT_W'(1))
                        state_next = S_IDLE;
                end
            end
            S_POPB:
            begin
                if (rem_reg != '0)
                begin
                    ctl.op   = OP_ROTATE;
                    rem_next = rem_reg - 1'b1;
                end
                else if (out_free)
                begin
                    emit        = 1'b1;
                    status_next = ST_OK;
                    data_next   = head;
                    last_next   = 1'b1;
                    ctl.op      = OP_POP_FRONT;
                    count_next  = count_reg - 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
            valid_next = 1'b1;
        else if (rsp_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rem_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        data_reg   <= data_next;
        last_reg   <= last_next;
    end

    assign count     = count_reg;
    assign rsp_valid = valid_reg;
    assign status    = status_reg;
    assign data_out  = data_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

/* sim/bounded_double_ended_queue_tb.sv */
`default_nettype none

module bounded_double_ended_queue_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dq_pkg::*;

    localparam int DEPTH        = DEFAULT_DEPTH;
    localparam int RANDOM_CMDS  = 100;
    // a pop back rotates the held words, a list sends one word per entry
    localparam int DRAIN_CYCLES = 4 * DEPTH + 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 60;
    localparam int HOLD_EVERY   = 50;
    localparam int HOLD_COUNT   = 2;
    localparam int SHOWN_ERRORS = 10;

    // command codes the block drops without a response
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

    // one command word as offered on the input side
    typedef struct {
        logic [CMD_W-1:0]         op;
        logic signed [WORD_W-1:0] word;
    } cmd_word_t;

    // one response word as it should leave the block
    typedef struct {
        status_t                  st;
        logic signed [WORD_W-1:0] data;
        logic                     is_last;
    } rsp_word_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cmd_valid = 1'b0;
    logic                       cmd_ready;
    logic [CMD_W-1:0]           command   = '0;
    logic signed [WORD_W-1:0]   value     = '0;
    logic                       rsp_valid;
    logic                       rsp_ready = 1'b0;
    logic [STATUS_W-1:0]        status;
    logic signed [WORD_W-1:0]   data_out;
    logic                       last;

    // command words still to be offered, response words still awaited
    cmd_word_t                  cmd_backlog[$];
    rsp_word_t                  awaited_words[$];

    // shadow copy of the deque contents
    logic signed [WORD_W-1:0]   shadow_ring[DEPTH];
    int                         shadow_head = 0;
    int                         shadow_fill = 0;

    int                         cmds_accepted = 0;
    int                         mismatch_count = 0;
    int                         cycle_count = 0;

    // sender side bookkeeping
    int                         tx_gap = 0;
    bit                         tx_calm = 1'b0;
    bit                         offering;
    cmd_word_t                  next_cmd;

    // receiver side bookkeeping
    int                         rx_wait = 0;
    bit                         rx_calm = 1'b0;
    rsp_word_t                  seen_exp;

    // long receiver hold-off, run from its own process
    int                         rsp_hold_left = 0;
    int                         holds_done = 0;

    bounded_double_ended_queue #(
        .DEPTH(DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .command   (command),
        .value     (value),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .data_out  (data_out),
        .last      (last)
    );

    always #1 clk = ~clk;

    function automatic void queue_awaited(status_t st, logic signed [WORD_W-1:0] d, logic l);
        rsp_word_t w;
        w.st      = st;
        w.data    = d;
        w.is_last = l;
        awaited_words.push_back(w);
    endfunction

    // apply one accepted command to the shadow deque and record the words it yields
    function automatic void apply_to_shadow_deque(logic [CMD_W-1:0] op,
                                                  logic signed [WORD_W-1:0] word);
        int i;
        case (op)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (shadow_fill >= DEPTH) begin
                    // full: refused, contents untouched
                    queue_awaited(ST_OVER, '0, 1'b1);
                end else begin
                    if (op == CMD_PUSH_FRONT) begin
                        shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                        shadow_ring[shadow_head] = word;
                    end else begin
                        shadow_ring[(shadow_head + shadow_fill) % DEPTH] = word;
                    end
                    shadow_fill++;
                    queue_awaited(ST_OK, '0, 1'b1);
                end
            end
            CMD_POP_FRONT:
            begin
                if (shadow_fill == 0) begin
                    queue_awaited(ST_UNDER, '0, 1'b1);
                end else begin
                    queue_awaited(ST_OK, shadow_ring[shadow_head], 1'b1);
                    shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_fill--;
                end
            end
            CMD_POP_BACK:
            begin
                if (shadow_fill == 0) begin
                    queue_awaited(ST_UNDER, '0, 1'b1);
                end else begin
                    queue_awaited(ST_OK, shadow_ring[(shadow_head + shadow_fill - 1) % DEPTH],
                                  1'b1);
                    shadow_fill--;
                end
            end
            CMD_LIST:
            begin
                if (shadow_fill == 0) begin
                    queue_awaited(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (i = 0; i < shadow_fill; i++) begin
                        queue_awaited(ST_OK, shadow_ring[(shadow_head + i) % DEPTH],
                                      i == shadow_fill - 1);
                    end
                end
            end
            default:
            begin
                // spare codes: no word comes back
            end
        endcase
    endfunction

    function automatic void queue_cmd(logic [CMD_W-1:0] op, logic signed [WORD_W-1:0] word);
        cmd_word_t c;
        c.op   = op;
        c.word = word;
        cmd_backlog.push_back(c);
    endfunction

    // data word with a bias toward the extremes
    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // stimulus: directed corner cases, then biased random fill and drain phases
    initial begin
        int  i;
        int  r;
        int  counted;
        int  phase_left;
        bit  filling;
        logic [CMD_W-1:0] op;

        // empty deque: list, both pops
        queue_cmd(CMD_LIST, pick_word());
        queue_cmd(CMD_POP_FRONT, pick_word());
        queue_cmd(CMD_POP_BACK, pick_word());
        // single entry taken out at either end
        queue_cmd(CMD_PUSH_BACK, 32'sh7fff_ffff);
        queue_cmd(CMD_POP_BACK, pick_word());
        queue_cmd(CMD_PUSH_FRONT, 32'sh8000_0000);
        queue_cmd(CMD_POP_FRONT, pick_word());
        // fill to the brim from both ends, wrapping the ring
        queue_cmd(CMD_PUSH_FRONT, '0);
        queue_cmd(CMD_PUSH_BACK, -32'sd1);
        for (i = 2; i < DEPTH; i++) begin
            queue_cmd(i % 2 ? CMD_PUSH_BACK : CMD_PUSH_FRONT, $urandom);
        end
        // full deque: both pushes refused, then a full list and a long pop back
        queue_cmd(CMD_PUSH_FRONT, 32'sh7fff_ffff);
        queue_cmd(CMD_PUSH_BACK, 32'sh8000_0000);
        queue_cmd(CMD_LIST, pick_word());
        queue_cmd(CMD_POP_BACK, pick_word());
        // spare codes are dropped
        queue_cmd(CMD_SPARE_A, pick_word());
        queue_cmd(CMD_SPARE_B, pick_word());
        queue_cmd(CMD_SPARE_C, pick_word());

        counted    = 0;
        filling    = 1'b1;
        phase_left = $urandom_range(20, 40);
        while (counted < RANDOM_CMDS) begin
            if (phase_left == 0) begin
                filling    = !filling;
                phase_left = $urandom_range(20, 40);
            end
            phase_left--;
            r = $urandom_range(0, 99);
            if (r < (filling ? 70 : 25)) begin
                op = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
            end else if (r < (filling ? 92 : 85)) begin
                op = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
            end else if (r < 97) begin
                op = CMD_LIST;
            end else begin
                op = CMD_SPARE_A + CMD_W'($urandom_range(0, 2));
            end
            if (op < CMD_SPARE_A) begin
                counted++;
            end
            queue_cmd(op, pick_word());
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // every command word taken, then every response word seen
        while (cmd_backlog.size() != 0 || cmd_valid) @(posedge clk);
        while (awaited_words.size() != 0) @(posedge clk);
        // room for any stray word still coming out
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && awaited_words.size() == 0) begin
            $display("PASS bounded_double_ended_queue");
        end else begin
            $display("FAIL bounded_double_ended_queue");
        end
        $finish;
    end

    // command side: offer words from the backlog, random gap after each accepted one
    always @(posedge clk) begin
        if (!rst_n) begin
            cmd_valid <= 1'b0;
        end else begin
            offering = cmd_valid;
            if (cmd_valid && cmd_ready) begin
                apply_to_shadow_deque(command, value);
                cmds_accepted <= cmds_accepted + 1;
                offering = 1'b0;
                // occasionally switch to or from back-to-back words
                if ($urandom_range(0, 11) == 0) begin
                    tx_calm = !tx_calm;
                end
                tx_gap = tx_calm ? 0 : $urandom_range(0, 8);
            end
            if (!offering) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                end else if (cmd_backlog.size() != 0) begin
                    next_cmd = cmd_backlog.pop_front();
                    command  <= next_cmd.op;
                    value    <= next_cmd.word;
                    offering = 1'b1;
                end
            end
            cmd_valid <= offering;
        end
    end

    // long hold-off on the response side so the block backs up and stalls commands
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_hold_left <= 0;
        end else if (rsp_hold_left != 0) begin
            rsp_hold_left <= rsp_hold_left - 1;
        end else if (holds_done < HOLD_COUNT &&
                     cmds_accepted >= HOLD_EVERY * (holds_done + 1)) begin
            rsp_hold_left <= HOLD_CYCLES;
            holds_done    <= holds_done + 1;
        end
    end

    // response side: check each word taken against the oldest awaited one
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_ready <= 1'b0;
        end else begin
            if (rsp_valid && rsp_ready) begin
                if (awaited_words.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOWN_ERRORS) begin
                        $display("unexpected word: status %0d data %0d last %0b",
                                 status, data_out, last);
                    end
                end else begin
                    seen_exp = awaited_words.pop_front();
                    if (status !== seen_exp.st || data_out !== seen_exp.data ||
                        last !== seen_exp.is_last) begin
                        mismatch_count++;
                        if (mismatch_count <= SHOWN_ERRORS) begin
                            $display("mismatch exp %0d/%0d/%0b got %0d/%0d/%0b",
                                     seen_exp.st, seen_exp.data, seen_exp.is_last,
                                     status, data_out, last);
                        end
                    end
                end
                if ($urandom_range(0, 11) == 0) begin
                    rx_calm = !rx_calm;
                end
                rx_wait = rx_calm ? 0 : $urandom_range(0, 8);
            end else if (rx_wait != 0) begin
                rx_wait--;
            end
            rsp_ready <= (rx_wait == 0) && (rsp_hold_left == 0);
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL bounded_double_ended_queue");
            $finish;
        end
    end

endmodule

`default_nettype wire

/* files.f */
+incdir+hdl
hdl/dq_pkg.sv
hdl/dq_cell.sv
hdl/dq_ctrl.sv
hdl/bounded_double_ended_queue.sv
sim/bounded_double_ended_queue_tb.sv
